@@ rtl/greedy_full_text_justifier_core_macros.svh @@
// assertion macros used by the justifier datapath
`ifndef GREEDY_FULL_TEXT_JUSTIFIER_CORE_MACROS_SVH
`define GREEDY_FULL_TEXT_JUSTIFIER_CORE_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define GFJ_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition must never be seen outside reset
`define GFJ_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	`GFJ_ASSERT(lbl, clk, rst_n, !(cond), msg)

`endif

@@ rtl/gfj_pkg.sv @@
// shared constants, controller states and command/status types of the justifier
package gfj_pkg;

	localparam int MAX_LINE  = 32;
	localparam int CHAR_W    = 8;
	localparam int CFG_W     = 6;
	localparam int WIDTH_RST = 16;

	localparam logic [CHAR_W-1:0] SPACE_CHAR = 8'h20;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_EMIT_RD,
		ST_EMIT_WR,
		ST_APPEND,
		ST_COPY_RD,
		ST_COPY_WR,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic take;
		logic div_start;
		logic emit_step;
		logic final_line;
		logic add_gap;
		logic copy_step;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic out_free;
		logic overflow;
		logic multi;
		logic div_done;
		logic emit_last;
		logic copy_last;
		logic text_end;
	} status_t;

endpackage

@@ rtl/greedy_full_text_justifier_core.sv @@
// top level of the greedy full text justifier
//
// channel   dir  handshake          payload
// s_        in   s_tvalid/s_tready  tdata char_in, tlast word_end, tuser text_end
// m_        out  m_tvalid/m_tready  tdata char_out, tlast line_last, tuser text_last,word_cut
// cfg_      in   cfg_valid/cfg_ready cfg_data line_width (always ready)
//
// a character inside a word is taken straight in idle; a word end moves the word
// from the word ram into the line ram, one ram read and one write per letter
// a line goes out with one line ram read and one output write per character, after
// the divider has worked out the gap spreading for a spread line
// s_tready is high only while idle; a stalled m_ side holds the sequencer in place
// arst_n clears all control state; the rams need no clearing pass
module greedy_full_text_justifier_core #(
	parameter int MaxLine = gfj_pkg::MAX_LINE
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [gfj_pkg::CHAR_W-1:0] s_tdata,   // [7:0] char_in
	input  logic                       s_tlast,
	input  logic                       s_tuser,   // [0] text_end
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [gfj_pkg::CHAR_W-1:0] m_tdata,   // [7:0] char_out
	output logic                       m_tlast,
	output logic [1:0]                 m_tuser,   // [0] text_last, [1] word_cut
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [gfj_pkg::CFG_W-1:0]  cfg_data
);

	gfj_pkg::cmd_t    cmd;
	gfj_pkg::status_t st;
	logic             text_last;
	logic             word_cut;

	gfj_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tlast (s_tlast),
		.s_tuser (s_tuser),
		.s_tready(s_tready),
		.st      (st),
		.cmd     (cmd)
	);

	gfj_datapath #(
		.MaxLine(MaxLine)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.st           (st),
		.char_in      (s_tdata),
		.text_end_in  (s_tuser),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.out_char     (m_tdata),
		.out_line_last(m_tlast),
		.out_text_last(text_last),
		.out_cut      (word_cut)
	);

	assign m_tuser = {word_cut, text_last};

endmodule

@@ rtl/gfj_ram.sv @@
// generic single write port ram with registered read
module gfj_ram #(
	parameter int Width = 8,
	parameter int Depth = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ rtl/gfj_div.sv @@
// multi-cycle restoring divider for the gap spreading quotient and remainder
module gfj_div #(
	parameter int W = 6
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] dividend,
	input  logic [W-1:0] divisor,
	output logic         done,
	output logic [W-1:0] quo,
	output logic [W-1:0] rem
);

	localparam int CntW = $clog2(W + 1);

	logic [W-1:0]    rem_q;
	logic [W-1:0]    quo_q;
	logic [W-1:0]    div_q;
	logic [CntW-1:0] cnt_q;
	logic            busy_q;
	logic            done_q;
	logic [W:0]      shifted;
	logic [W:0]      diff;
	logic            ge;

	assign shifted = {rem_q, quo_q[W-1]};
	assign diff    = shifted - {1'b0, div_q};
	assign ge      = !diff[W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CntW'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CntW'(1);
				if (cnt_q == CntW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[W-1:0] : shifted[W-1:0];
			quo_q <= {quo_q[W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
	assign rem  = rem_q;

endmodule

@@ rtl/gfj_datapath.sv @@
// word and line stores, line counters, gap spreading and output register
`include "greedy_full_text_justifier_core_macros.svh"

module gfj_datapath #(
	parameter int MaxLine = gfj_pkg::MAX_LINE
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  gfj_pkg::cmd_t                cmd,
	output gfj_pkg::status_t             st,
	input  logic [gfj_pkg::CHAR_W-1:0]   char_in,
	input  logic                         text_end_in,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [gfj_pkg::CFG_W-1:0]    cfg_data,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [gfj_pkg::CHAR_W-1:0]   out_char,
	output logic                         out_line_last,
	output logic                         out_text_last,
	output logic                         out_cut
);

	localparam int AW = $clog2(MaxLine);
	localparam int CW = $clog2(MaxLine + 1);
	localparam int RstWidth = (gfj_pkg::WIDTH_RST > MaxLine) ? MaxLine : gfj_pkg::WIDTH_RST;

	logic [CW-1:0]      w_q;
	logic [CW-1:0]      wl_q;
	logic               lost_q;
	logic               text_end_q;
	logic [CW-1:0]      used_q;
	logic [CW-1:0]      letters_q;
	logic [CW-1:0]      wc_q;
	logic               cut_q;
	logic [MaxLine-1:0] gap_q;
	logic [CW-1:0]      c_q;
	logic [CW-1:0]      i_q;
	logic [CW-1:0]      pos_q;
	logic [CW-1:0]      rep_q;
	logic [CW-1:0]      gap_cnt_q;

	logic               out_valid_q;
	logic [gfj_pkg::CHAR_W-1:0] out_char_q;
	logic               out_line_last_q;
	logic               out_text_last_q;
	logic               out_cut_q;

	logic [gfj_pkg::CFG_W-1:0] cfg_clamped;
	logic                      word_we;
	logic                      line_we;
	logic [gfj_pkg::CHAR_W-1:0] line_wdata;
	logic [gfj_pkg::CHAR_W-1:0] word_rdata;
	logic [gfj_pkg::CHAR_W-1:0] line_rdata;
	logic [CW:0]               need;
	logic                      div_done;
	logic [CW-1:0]             div_quo;
	logic [CW-1:0]             div_rem;
	logic                      out_free;
	logic                      spread;
	logic                      step;
	logic                      emit_last;
	logic [CW-1:0]             n_spaces;
	logic [gfj_pkg::CHAR_W-1:0] emit_char;
	logic                      emit_gap;
	logic                      emit_adv;

	assign cfg_ready = 1'b1;

	always_comb begin
		cfg_clamped = cfg_data;
		if (cfg_data == '0) begin
			cfg_clamped = gfj_pkg::CFG_W'(1);
		end else if (cfg_data > gfj_pkg::CFG_W'(MaxLine)) begin
			cfg_clamped = gfj_pkg::CFG_W'(MaxLine);
		end
	end

	assign word_we    = cmd.take && (wl_q < w_q);
	assign line_we    = (cmd.add_gap && (wc_q != '0)) || cmd.copy_step;
	assign line_wdata = cmd.add_gap ? gfj_pkg::SPACE_CHAR : word_rdata;

	gfj_ram #(
		.Width(gfj_pkg::CHAR_W),
		.Depth(MaxLine)
	) u_word_ram (
		.clk  (clk),
		.we   (word_we),
		.waddr(wl_q[AW-1:0]),
		.wdata(char_in),
		.raddr(c_q[AW-1:0]),
		.rdata(word_rdata)
	);

	gfj_ram #(
		.Width(gfj_pkg::CHAR_W),
		.Depth(MaxLine)
	) u_line_ram (
		.clk  (clk),
		.we   (line_we),
		.waddr(used_q[AW-1:0]),
		.wdata(line_wdata),
		.raddr(i_q[AW-1:0]),
		.rdata(line_rdata)
	);

	gfj_div #(
		.W(CW)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.div_start),
		.dividend(w_q - letters_q),
		.divisor (wc_q - CW'(1)),
		.done    (div_done),
		.quo     (div_quo),
		.rem     (div_rem)
	);

	assign need      = {1'b0, used_q} + {1'b0, wl_q} + (CW + 1)'(1);
	assign out_free  = !out_valid_q || out_ready;
	assign spread    = !cmd.final_line && (wc_q > CW'(1));
	assign step      = cmd.emit_step && out_free;
	assign emit_last = pos_q == (w_q - CW'(1));
	assign emit_gap  = gap_q[i_q[AW-1:0]];
	assign emit_adv  = (rep_q == '0) && (i_q < used_q);
	assign n_spaces  = spread ? (div_quo + CW'(gap_cnt_q < div_rem)) : CW'(1);

	always_comb begin
		emit_char = gfj_pkg::SPACE_CHAR;
		if (emit_adv && !emit_gap) begin
			emit_char = line_rdata;
		end
	end

	always_comb begin
		st           = '0;
		st.out_free  = out_free;
		st.overflow  = (wc_q != '0) && (need > {1'b0, w_q});
		st.multi     = wc_q > CW'(1);
		st.div_done  = div_done;
		st.emit_last = emit_last;
		st.copy_last = (c_q + CW'(1)) == wl_q;
		st.text_end  = text_end_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q        <= CW'(RstWidth);
			wl_q       <= '0;
			lost_q     <= 1'b0;
			text_end_q <= 1'b0;
			used_q     <= '0;
			letters_q  <= '0;
			wc_q       <= '0;
			cut_q      <= 1'b0;
			gap_q      <= '0;
			c_q        <= '0;
			i_q        <= '0;
			pos_q      <= '0;
			rep_q      <= '0;
			gap_cnt_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_valid) begin
				w_q       <= cfg_clamped[CW-1:0];
				wl_q      <= '0;
				lost_q    <= 1'b0;
				used_q    <= '0;
				letters_q <= '0;
				wc_q      <= '0;
				cut_q     <= 1'b0;
				gap_q     <= '0;
				c_q       <= '0;
			end else begin
				if (cmd.take) begin
					text_end_q <= text_end_in;
					if (word_we) begin
						wl_q <= wl_q + CW'(1);
					end else begin
						lost_q <= 1'b1;
					end
				end
				if (cmd.add_gap && (wc_q != '0)) begin
					gap_q[used_q[AW-1:0]] <= 1'b1;
					used_q <= used_q + CW'(1);
				end
				if (cmd.copy_step) begin
					used_q <= used_q + CW'(1);
					c_q    <= c_q + CW'(1);
				end
				if (cmd.finish) begin
					letters_q <= letters_q + wl_q;
					wc_q      <= wc_q + CW'(1);
					cut_q     <= cut_q || lost_q;
					wl_q      <= '0;
					lost_q    <= 1'b0;
					c_q       <= '0;
				end
				if (step) begin
					out_valid_q <= 1'b1;
					pos_q       <= pos_q + CW'(1);
					if (rep_q != '0) begin
						rep_q <= rep_q - CW'(1);
					end else if (emit_adv) begin
						i_q <= i_q + CW'(1);
						if (emit_gap) begin
							rep_q     <= n_spaces - CW'(1);
							gap_cnt_q <= gap_cnt_q + CW'(1);
						end
					end
					if (emit_last) begin
						used_q    <= '0;
						letters_q <= '0;
						wc_q      <= '0;
						cut_q     <= 1'b0;
						gap_q     <= '0;
						i_q       <= '0;
						pos_q     <= '0;
						rep_q     <= '0;
						gap_cnt_q <= '0;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			out_char_q      <= emit_char;
			out_line_last_q <= emit_last;
			out_text_last_q <= emit_last && cmd.final_line;
			out_cut_q       <= cut_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign out_char      = out_char_q;
	assign out_line_last = out_line_last_q;
	assign out_text_last = out_text_last_q;
	assign out_cut       = out_cut_q;

	`GFJ_ASSERT(a_used_fits, clk, arst_n, used_q <= w_q, "pending line exceeds line width")
	`GFJ_ASSERT(a_word_fits, clk, arst_n, wl_q <= w_q, "stored word exceeds line width")
	`GFJ_ASSERT(a_gap_count, clk, arst_n, $countones(gap_q) <= wc_q, "more gaps than words")
	`GFJ_ASSERT_NEVER(a_pos_range, clk, arst_n, pos_q >= w_q, "output position past line end")

endmodule

@@ rtl/gfj_ctrl.sv @@
// controller state machine sequencing word intake, line append and line output
module gfj_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	input  logic             s_tlast,
	input  logic             s_tuser,
	output logic             s_tready,
	input  gfj_pkg::status_t st,
	output gfj_pkg::cmd_t    cmd
);

	gfj_pkg::state_t state_q;
	gfj_pkg::state_t state_d;
	logic            final_q;
	logic            final_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gfj_pkg::ST_IDLE;
			final_q <= 1'b0;
		end else begin
			state_q <= state_d;
			final_q <= final_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		final_d  = final_q;
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			gfj_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.take = 1'b1;
					if (s_tlast || s_tuser) begin
						state_d = gfj_pkg::ST_CHECK;
					end
				end
			end
			gfj_pkg::ST_CHECK: begin
				if (st.overflow) begin
					final_d = 1'b0;
					state_d = st.multi ? gfj_pkg::ST_DIV_GO : gfj_pkg::ST_EMIT_RD;
				end else begin
					state_d = gfj_pkg::ST_APPEND;
				end
			end
			gfj_pkg::ST_DIV_GO: begin
				cmd.div_start = 1'b1;
				state_d = gfj_pkg::ST_DIV_WAIT;
			end
			gfj_pkg::ST_DIV_WAIT: begin
				if (st.div_done) begin
					state_d = gfj_pkg::ST_EMIT_RD;
				end
			end
			gfj_pkg::ST_EMIT_RD: begin
				state_d = gfj_pkg::ST_EMIT_WR;
			end
			gfj_pkg::ST_EMIT_WR: begin
				cmd.final_line = final_q;
				if (st.out_free) begin
					cmd.emit_step = 1'b1;
					if (st.emit_last) begin
						state_d = final_q ? gfj_pkg::ST_IDLE : gfj_pkg::ST_APPEND;
					end else begin
						state_d = gfj_pkg::ST_EMIT_RD;
					end
				end
			end
			gfj_pkg::ST_APPEND: begin
				cmd.add_gap = 1'b1;
				state_d = gfj_pkg::ST_COPY_RD;
			end
			gfj_pkg::ST_COPY_RD: begin
				state_d = gfj_pkg::ST_COPY_WR;
			end
			gfj_pkg::ST_COPY_WR: begin
				cmd.copy_step = 1'b1;
				state_d = st.copy_last ? gfj_pkg::ST_FINISH : gfj_pkg::ST_COPY_RD;
			end
			gfj_pkg::ST_FINISH: begin
				cmd.finish = 1'b1;
				if (st.text_end) begin
					final_d = 1'b1;
					state_d = gfj_pkg::ST_EMIT_RD;
				end else begin
					state_d = gfj_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = gfj_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

@@ test/testbench.sv @@
// self-checking testbench for the justifier core: directed table, then random texts
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import gfj_pkg::*;

	localparam int IdleLimit = 2000;
	localparam int SettleCycles = 100;
	localparam int NumPhases = 8;
	localparam int PhaseItems = 15;

	typedef enum logic {OP_CHAR, OP_WIDTH} row_op_t;

	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		logic              line_last;
		logic              text_last;
		logic              cut;
	} line_char_t;

	typedef struct packed {
		row_op_t           op;
		logic [CHAR_W-1:0] data;
		logic              word_end;
		logic              text_end;
		logic              typed;
		line_char_t        want;
	} stim_row_t;

	localparam stim_row_t DirRows [21] = '{
		'{OP_CHAR,  8'h5A, 1'b1, 1'b1, 1'b0, '0},
		'{OP_WIDTH, 8'd0,  1'b0, 1'b0, 1'b0, '0},
		'{OP_CHAR,  8'h41, 1'b1, 1'b1, 1'b1, '{8'h41, 1'b1, 1'b1, 1'b0}},
		'{OP_CHAR,  8'h42, 1'b0, 1'b0, 1'b0, '0},
		'{OP_CHAR,  8'h43, 1'b0, 1'b1, 1'b1, '{8'h42, 1'b1, 1'b1, 1'b1}},
		'{OP_CHAR,  8'h00, 1'b1, 1'b1, 1'b1, '{8'h00, 1'b1, 1'b1, 1'b0}},
		'{OP_CHAR,  8'hFF, 1'b1, 1'b1, 1'b1, '{8'hFF, 1'b1, 1'b1, 1'b0}},
		'{OP_CHAR,  8'h20, 1'b0, 1'b1, 1'b1, '{8'h20, 1'b1, 1'b1, 1'b0}},
		'{OP_WIDTH, 8'd63, 1'b0, 1'b0, 1'b0, '0},
		'{OP_CHAR,  8'h71, 1'b1, 1'b1, 1'b0, '0},
		'{OP_WIDTH, 8'd10, 1'b0, 1'b0, 1'b0, '0},
		'{OP_CHAR,  8'h61, 1'b1, 1'b0, 1'b0, '0},
		'{OP_CHAR,  8'h62, 1'b1, 1'b0, 1'b0, '0},
		'{OP_CHAR,  8'h63, 1'b1, 1'b0, 1'b0, '0},
		'{OP_CHAR,  8'h64, 1'b0, 1'b0, 1'b0, '0},
		'{OP_CHAR,  8'h65, 1'b0, 1'b0, 1'b0, '0},
		'{OP_CHAR,  8'h66, 1'b0, 1'b0, 1'b0, '0},
		'{OP_CHAR,  8'h67, 1'b0, 1'b0, 1'b0, '0},
		'{OP_CHAR,  8'h68, 1'b1, 1'b0, 1'b0, '0},
		'{OP_CHAR,  8'h69, 1'b0, 1'b0, 1'b0, '0},
		'{OP_CHAR,  8'h6A, 1'b1, 1'b1, 1'b0, '0}
	};

	localparam logic [CFG_W-1:0] PhaseWidths [6] = '{6'd1, 6'd32, 6'd0, 6'd63, 6'd2, 6'd7};

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [CHAR_W-1:0] s_tdata = '0;
	logic              s_tlast = 1'b0;
	logic              s_tuser = 1'b0;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [CHAR_W-1:0] m_tdata;
	logic              m_tlast;
	logic [1:0]        m_tuser;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [CFG_W-1:0]  cfg_data = '0;

	// line model state
	int unsigned       width_now;
	logic [CHAR_W-1:0] line_buf [MAX_LINE];
	logic [CHAR_W-1:0] word_buf [MAX_LINE];
	bit                gap_at [MAX_LINE];
	int unsigned       line_len;
	int unsigned       line_letters;
	int unsigned       line_words;
	int unsigned       word_len;
	bit                line_cut;
	bit                word_trimmed;

	line_char_t        expected_chars [$];
	int                mismatches = 0;
	bit                idle_on = 1'b1;
	int                rx_wait = 0;
	int                quiet_cycles = 0;

	greedy_full_text_justifier_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	function automatic void clear_line_model();
		line_len = 0;
		line_letters = 0;
		line_words = 0;
		line_cut = 1'b0;
		foreach (gap_at[i]) gap_at[i] = 1'b0;
	endfunction

	function automatic void clear_word_model();
		word_len = 0;
		word_trimmed = 1'b0;
	endfunction

	function automatic void put_out_char(logic [CHAR_W-1:0] ch, int unsigned pos, bit last_text);
		line_char_t c;
		c.ch = ch;
		c.line_last = (pos + 1 == width_now);
		c.text_last = last_text && (pos + 1 == width_now);
		c.cut = line_cut;
		expected_chars = {expected_chars, c};
	endfunction

	// lays out the pending line at exactly width_now characters
	function automatic void emit_line(bit last_text);
		bit                spread;
		int unsigned       spare;
		int unsigned       per_gap;
		int unsigned       wide_gaps;
		int unsigned       gap_no;
		int unsigned       pos;
		int unsigned       n;
		logic [CHAR_W-1:0] ch;
		spread = !last_text && line_words > 1;
		spare = (line_letters <= width_now) ? width_now - line_letters : 0;
		per_gap = 0;
		wide_gaps = 0;
		gap_no = 0;
		pos = 0;
		if (spread) begin
			per_gap = spare / (line_words - 1);
			wide_gaps = spare % (line_words - 1);
		end
		for (int unsigned i = 0; i < line_len && i < MAX_LINE; i++) begin
			n = 1;
			ch = line_buf[i];
			if (gap_at[i]) begin
				gap_no++;
				ch = SPACE_CHAR;
				if (spread) n = per_gap + ((gap_no <= wide_gaps) ? 1 : 0);
			end
			for (int unsigned j = 0; j < n && pos < width_now; j++) begin
				put_out_char(ch, pos, last_text);
				pos++;
			end
		end
		while (pos < width_now) begin
			put_out_char(SPACE_CHAR, pos, last_text);
			pos++;
		end
		clear_line_model();
	endfunction

	function automatic void predict_width(logic [CFG_W-1:0] v);
		if (v == 0) width_now = 1;
		else if (int'(v) > MAX_LINE) width_now = MAX_LINE;
		else width_now = int'(v);
		clear_line_model();
		clear_word_model();
	endfunction

	function automatic void predict_char(logic [CHAR_W-1:0] ch, logic we, logic te);
		if (word_len < width_now && word_len < MAX_LINE) begin
			word_buf[word_len] = ch;
			word_len++;
		end else begin
			word_trimmed = 1'b1;
		end
		if (!(we || te)) return;
		if (line_words > 0 && line_len + 1 + word_len > width_now) emit_line(1'b0);
		if (line_words > 0 && line_len < MAX_LINE) begin
			gap_at[line_len] = 1'b1;
			line_buf[line_len] = SPACE_CHAR;
			line_len++;
		end
		for (int unsigned i = 0; i < word_len && line_len < MAX_LINE; i++) begin
			line_buf[line_len] = word_buf[i];
			line_len++;
		end
		line_letters += word_len;
		line_words++;
		if (word_trimmed) line_cut = 1'b1;
		clear_word_model();
		if (te) emit_line(1'b1);
	endfunction

	task automatic report_mismatch(input string what);
		if (mismatches < 40) $display("tb: mismatch at %0t: %s", $realtime, what);
		mismatches++;
	endtask

	// one character transaction on the s_ side; typed rows replace the modeled result
	task automatic feed_char(input logic [CHAR_W-1:0] ch, input logic we, input logic te,
			input logic typed, input line_char_t want);
		int          gap;
		int unsigned held;
		gap = idle_on ? int'($urandom_range(0, 3)) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= ch;
		s_tlast <= we;
		s_tuser <= te;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		held = expected_chars.size();
		predict_char(ch, we, te);
		if (typed) begin
			while (expected_chars.size() > held) void'(expected_chars.pop_back());
			expected_chars = {expected_chars, want};
		end
	endtask

	// width write once the core has drained and settled
	task automatic write_width(input logic [CFG_W-1:0] v);
		s_tvalid <= 1'b0;
		while (expected_chars.size() != 0) @(posedge clk);
		repeat (SettleCycles) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		predict_width(v);
	endtask

	always @(posedge clk) begin : rx_side
		line_char_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (expected_chars.size() == 0) begin
					report_mismatch("output transaction with nothing expected");
				end else begin
					want = expected_chars.pop_front();
					if (m_tdata !== want.ch)
						report_mismatch($sformatf("char_out %h, expected %h", m_tdata, want.ch));
					if (m_tlast !== want.line_last)
						report_mismatch($sformatf("line_last %b, expected %b", m_tlast,
							want.line_last));
					if (m_tuser[0] !== want.text_last)
						report_mismatch($sformatf("text_last %b, expected %b", m_tuser[0],
							want.text_last));
					if (m_tuser[1] !== want.cut)
						report_mismatch($sformatf("word_cut %b, expected %b", m_tuser[1],
							want.cut));
				end
				rx_wait = idle_on ? int'($urandom_range(0, 3)) : 0;
			end else if (rx_wait > 0) begin
				rx_wait--;
			end
			m_tready <= (rx_wait == 0);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= IdleLimit) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin : stimulus
		int               phase_items;
		int               len;
		int               pick;
		bit               ends_text;
		logic [CFG_W-1:0] w;
		width_now = WIDTH_RST;
		clear_line_model();
		clear_word_model();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DirRows[r]) begin
			if (DirRows[r].op == OP_WIDTH)
				write_width(DirRows[r].data[CFG_W-1:0]);
			else
				feed_char(DirRows[r].data, DirRows[r].word_end, DirRows[r].text_end,
					DirRows[r].typed, DirRows[r].want);
		end

		for (int p = 0; p < NumPhases; p++) begin
			w = (p < 6) ? PhaseWidths[p] : CFG_W'($urandom_range(0, 63));
			write_width(w);
			idle_on = ($urandom_range(0, 3) != 0);
			phase_items = 0;
			while (phase_items < PhaseItems) begin
				pick = int'($urandom_range(0, 99));
				if (pick < 12) begin
					// stray character with random flags
					feed_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
						($urandom_range(0, 7) == 0), 1'b0, '0);
					phase_items++;
				end else begin
					if (pick < 75) len = int'($urandom_range(1, (width_now < 6) ? width_now : 6));
					else if (pick < 92) len = int'($urandom_range(1, width_now));
					else len = int'($urandom_range(width_now + 1, width_now + 3));
					ends_text = ($urandom_range(0, 4) == 0);
					for (int k = 1; k <= len; k++)
						feed_char(8'($urandom_range(0, 255)),
							(k == len) && (!ends_text || $urandom_range(0, 1) == 1),
							(k == len) && ends_text, 1'b0, '0);
					phase_items += len;
				end
			end
			// most phases close the text; the rest leave a line for the width write to drop
			if ($urandom_range(0, 3) != 0)
				feed_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1, 1'b0, '0);
		end

		s_tvalid <= 1'b0;
		while (expected_chars.size() != 0) @(posedge clk);
		repeat (SettleCycles) @(posedge clk);
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
